FILE: sv/tws_pkg.sv
package tws_pkg;

  typedef struct packed {
    logic               inlet_open_cmd;
    logic               inlet_close_cmd;
    logic               outlet_open_cmd;
    logic               outlet_close_cmd;
    logic signed [31:0] supply_pressure;
  } in_t;

  typedef struct packed {
    logic signed [31:0] tank_pressure;
    logic [22:0]        inlet_position;
    logic [22:0]        outlet_position;
  } out_t;

  localparam int TS_W  = 20;
  localparam int POS_W = 23;
  localparam int P_W   = 32;
  localparam int MAG_W = 32;
  localparam int TT_W  = 31;
  localparam int PROD_W = TS_W + MAG_W;
  localparam int NUM_W  = 56;
  localparam int DIV_ITERS = NUM_W / 2;
  localparam int CNT_W  = $clog2(DIV_ITERS + 1);

  localparam logic [TS_W-1:0]  TS_RESET    = 20'd6554;
  localparam logic [POS_W-1:0] POS_MAX     = 23'd6553600;
  localparam logic [TT_W-1:0]  TEN_T_BASE  = 31'd1310720000;
  localparam logic [TT_W-1:0]  TEN_T_SLOPE = 31'd198;

  // step addresses
  localparam logic [2:0] STEP_IDLE  = 3'd0;
  localparam logic [2:0] STEP_VALVE = 3'd1;
  localparam logic [2:0] STEP_PREP  = 3'd2;
  localparam logic [2:0] STEP_MUL   = 3'd3;
  localparam logic [2:0] STEP_SCALE = 3'd4;
  localparam logic [2:0] STEP_DIV   = 3'd5;
  localparam logic [2:0] STEP_APPLY = 3'd6;
  localparam logic [2:0] STEP_EMIT  = 3'd7;

  // datapath operations
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_VALVE = 3'd1;
  localparam logic [2:0] OP_PREP  = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_SCALE = 3'd4;
  localparam logic [2:0] OP_DIV   = 3'd5;
  localparam logic [2:0] OP_APPLY = 3'd6;
  localparam logic [2:0] OP_EMIT  = 3'd7;

  // jump conditions
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_NO_IN    = 3'd1;
  localparam logic [2:0] COND_HOLD     = 3'd2;
  localparam logic [2:0] COND_DIV_MORE = 3'd3;
  localparam logic [2:0] COND_OUT_FULL = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] cond;
    logic [2:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  function automatic ctl_word_t ucode(input logic [2:0] pc);
    ctl_word_t w;
    begin
      unique case (pc)
        STEP_IDLE:  w = '{op: OP_IDLE,  cond: COND_NO_IN,    target: STEP_IDLE};
        STEP_VALVE: w = '{op: OP_VALVE, cond: COND_NONE,     target: STEP_IDLE};
        STEP_PREP:  w = '{op: OP_PREP,  cond: COND_HOLD,     target: STEP_EMIT};
        STEP_MUL:   w = '{op: OP_MUL,   cond: COND_NONE,     target: STEP_IDLE};
        STEP_SCALE: w = '{op: OP_SCALE, cond: COND_NONE,     target: STEP_IDLE};
        STEP_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_MORE, target: STEP_DIV};
        STEP_APPLY: w = '{op: OP_APPLY, cond: COND_NONE,     target: STEP_IDLE};
        STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_FULL, target: STEP_EMIT};
      endcase
      return w;
    end
  endfunction

endpackage

FILE: sv/tank_with_two_valves_step_core.sv
// Pressure receiver plant step: one beat in is one simulation tick, one beat out carries the
// new tank pressure and both valve positions. The datapath is run by an eight-step microcode
// table. A tick in which either valve is open runs the valve, prep, multiply, scale,
// two-bit-per-cycle divide (forming h*(target-P)/T) and apply steps before its result is
// loaded into the output register; with both valves shut, prep jumps to emit. The next beat is
// taken once the sequencer returns to its idle step, while the previous result may still wait.
// The time step register (cfg_wdata, Q4.16 s) should only be written between ticks.
module tank_with_two_valves_step_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tws_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tws_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [tws_pkg::TS_W-1:0]    cfg_wdata
);

  logic [2:0]                 pc_r, pc_nxt;
  tws_pkg::ctl_word_t         cw;
  logic                       jump;

  logic [tws_pkg::TS_W-1:0]   ts_r, ts_nxt;
  tws_pkg::in_t               in_r, in_nxt;
  logic [tws_pkg::POS_W-1:0]  inl_pos_r, inl_pos_nxt;
  logic [tws_pkg::POS_W-1:0]  outl_pos_r, outl_pos_nxt;
  logic [tws_pkg::P_W-1:0]    press_r, press_nxt;
  logic [tws_pkg::TT_W-1:0]   ten_t_r, ten_t_nxt;
  logic [tws_pkg::MAG_W-1:0]  mag_r, mag_nxt;
  logic                       neg_r, neg_nxt;
  logic [tws_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tws_pkg::out_t              out_r, out_nxt;

  logic [tws_pkg::POS_W-1:0]  delta;
  logic                       use_inlet;
  logic [tws_pkg::POS_W-1:0]  sel_pos;
  logic [tws_pkg::P_W-1:0]    target;
  logic [tws_pkg::TT_W-1:0]   slope;
  logic [tws_pkg::P_W:0]      diff;
  logic [tws_pkg::P_W:0]      diff_neg;
  logic [tws_pkg::P_W-1:0]    q_sat;
  logic [tws_pkg::P_W+1:0]    sum;
  logic                       out_full;

  tws_pkg::div_ctl_t          div_ctl;
  logic [tws_pkg::NUM_W-1:0]  div_num;
  logic [tws_pkg::NUM_W-1:0]  div_quo;
  logic                       div_last;

  function automatic logic [tws_pkg::POS_W-1:0] move_valve(
    input logic [tws_pkg::POS_W-1:0] pos,
    input logic                      op,
    input logic                      cl,
    input logic [tws_pkg::POS_W-1:0] dl
  );
    logic [tws_pkg::POS_W:0] up;
    begin
      up = {1'b0, pos} + {1'b0, dl};
      if (op && !cl) begin
        return (up > {1'b0, tws_pkg::POS_MAX}) ? tws_pkg::POS_MAX : up[tws_pkg::POS_W-1:0];
      end else if (cl && !op) begin
        return (dl >= pos) ? '0 : tws_pkg::POS_W'(pos - dl);
      end else begin
        return pos;
      end
    end
  endfunction

  assign cw       = tws_pkg::ucode(pc_r);
  assign out_full = out_valid_r && !out_ready;

  always_comb begin
    case (cw.cond)
      tws_pkg::COND_NO_IN:    jump = !in_valid;
      tws_pkg::COND_HOLD:     jump = (inl_pos_r == '0) && (outl_pos_r == '0);
      tws_pkg::COND_DIV_MORE: jump = !div_last;
      tws_pkg::COND_OUT_FULL: jump = out_full;
      default:                jump = 1'b0;
    endcase
    pc_nxt = jump ? cw.target : pc_r + 3'd1;
  end

  // shared datapath terms
  always_comb begin
    delta     = tws_pkg::POS_W'({ts_r, 2'b00}) + tws_pkg::POS_W'(ts_r);
    use_inlet = inl_pos_r != '0;
    sel_pos   = use_inlet ? inl_pos_r : outl_pos_r;
    target    = use_inlet ? in_r.supply_pressure : '0;
    slope     = tws_pkg::TT_W'(sel_pos) * tws_pkg::TEN_T_SLOPE;
    diff      = {target[tws_pkg::P_W-1], target} - {press_r[tws_pkg::P_W-1], press_r};
    diff_neg  = -diff;
    div_num   = tws_pkg::NUM_W'({prod_r, 3'b000}) + tws_pkg::NUM_W'({prod_r, 1'b0});
    q_sat     = (|div_quo[tws_pkg::NUM_W-1:tws_pkg::P_W]) ? '1 : div_quo[tws_pkg::P_W-1:0];
    sum       = neg_r ? {{2{press_r[tws_pkg::P_W-1]}}, press_r} - {2'b00, q_sat}
                      : {{2{press_r[tws_pkg::P_W-1]}}, press_r} + {2'b00, q_sat};
  end

  always_comb begin
    ts_nxt        = cfg_we ? cfg_wdata : ts_r;
    in_nxt        = in_r;
    inl_pos_nxt   = inl_pos_r;
    outl_pos_nxt  = outl_pos_r;
    press_nxt     = press_r;
    ten_t_nxt     = ten_t_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_full;
    div_ctl       = '0;
    in_ready      = 1'b0;

    unique case (cw.op)
      tws_pkg::OP_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt = in_data;
        end
      end
      tws_pkg::OP_VALVE: begin
        inl_pos_nxt  = move_valve(inl_pos_r, in_r.inlet_open_cmd, in_r.inlet_close_cmd, delta);
        outl_pos_nxt = move_valve(outl_pos_r, in_r.outlet_open_cmd, in_r.outlet_close_cmd,
                                  delta);
      end
      tws_pkg::OP_PREP: begin
        ten_t_nxt = tws_pkg::TEN_T_BASE - slope;
        neg_nxt   = diff[tws_pkg::P_W];
        mag_nxt   = diff[tws_pkg::P_W] ? diff_neg[tws_pkg::P_W-1:0] : diff[tws_pkg::P_W-1:0];
      end
      tws_pkg::OP_MUL: begin
        prod_nxt = tws_pkg::PROD_W'(ts_r) * tws_pkg::PROD_W'(mag_r);
      end
      tws_pkg::OP_SCALE: begin
        div_ctl.load = 1'b1;
      end
      tws_pkg::OP_DIV: begin
        div_ctl.step = 1'b1;
      end
      tws_pkg::OP_APPLY: begin
        if (sum[tws_pkg::P_W+1:tws_pkg::P_W-1] == 3'b000 ||
            sum[tws_pkg::P_W+1:tws_pkg::P_W-1] == 3'b111) begin
          press_nxt = sum[tws_pkg::P_W-1:0];
        end else begin
          press_nxt = sum[tws_pkg::P_W+1] ? {1'b1, {(tws_pkg::P_W-1){1'b0}}}
                                          : {1'b0, {(tws_pkg::P_W-1){1'b1}}};
        end
      end
      tws_pkg::OP_EMIT: begin
        if (!out_full) begin
          out_valid_nxt           = 1'b1;
          out_nxt.tank_pressure   = press_r;
          out_nxt.inlet_position  = inl_pos_r;
          out_nxt.outlet_position = outl_pos_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tws_pkg::STEP_IDLE;
      ts_r        <= tws_pkg::TS_RESET;
      inl_pos_r   <= '0;
      outl_pos_r  <= '0;
      press_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      ts_r        <= ts_nxt;
      inl_pos_r   <= inl_pos_nxt;
      outl_pos_r  <= outl_pos_nxt;
      press_r     <= press_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r    <= in_nxt;
    ten_t_r <= ten_t_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    out_r   <= out_nxt;
  end

  tws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (ten_t_r),
    .quo   (div_quo),
    .last  (div_last)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> pc_r == tws_pkg::STEP_VALVE)
    else $error("accepted beat did not start the valve step");

  assert property (@(posedge clk) disable iff (!rst_n)
    inl_pos_r <= tws_pkg::POS_MAX && outl_pos_r <= tws_pkg::POS_MAX)
    else $error("valve position beyond full open");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == tws_pkg::STEP_EMIT)
    else $error("result appeared outside the emit step");

  assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == tws_pkg::STEP_APPLY |-> $past(pc_r) == tws_pkg::STEP_DIV && $past(div_last))
    else $error("pressure update before the divider finished");

endmodule

FILE: sv/tws_div.sv
module tws_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tws_pkg::div_ctl_t         ctl,
  input  logic [tws_pkg::NUM_W-1:0] num,
  input  logic [tws_pkg::TT_W-1:0]  den,
  output logic [tws_pkg::NUM_W-1:0] quo,
  output logic                      last
);

  logic [tws_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [tws_pkg::TT_W-1:0]  rem_r, rem_nxt;
  logic [tws_pkg::TT_W-1:0]  den_r, den_nxt;
  logic [tws_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tws_pkg::TT_W:0]    r1, r2, d_ext;
  logic [tws_pkg::TT_W-1:0]  m1, m2;
  logic                      ge1, ge2;

  // two restoring subtract steps per cycle
  always_comb begin
    d_ext = {1'b0, den_r};
    r1    = {rem_r, num_r[tws_pkg::NUM_W-1]};
    ge1   = r1 >= d_ext;
    m1    = ge1 ? tws_pkg::TT_W'(r1 - d_ext) : r1[tws_pkg::TT_W-1:0];
    r2    = {m1, num_r[tws_pkg::NUM_W-2]};
    ge2   = r2 >= d_ext;
    m2    = ge2 ? tws_pkg::TT_W'(r2 - d_ext) : r2[tws_pkg::TT_W-1:0];

    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      num_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = tws_pkg::CNT_W'(tws_pkg::DIV_ITERS);
    end else if (ctl.step) begin
      num_nxt = {num_r[tws_pkg::NUM_W-3:0], ge1, ge2};
      rem_nxt = m2;
      cnt_nxt = cnt_r - tws_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = num_r;
  assign last = cnt_r == tws_pkg::CNT_W'(1);

endmodule
